### rtl/core/ddas_pkg.sv
// shared types and constants for the decimal digit add/sub block
package ddas_pkg;

  localparam int unsigned DigitW = 4;
  localparam int unsigned PosW   = 5;

  localparam logic [DigitW-1:0] MaxDigit = 4'd9;
  localparam logic [DigitW:0]   Radix    = 5'd10;

  // digit pair held in one cell: a is the first operand, b the second
  typedef struct packed {
    logic [DigitW-1:0] a;
    logic [DigitW-1:0] b;
  } pair_t;

  // what every cell does in a cycle
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_SHIFT_A,
    CELL_SHIFT_B,
    CELL_FROM_LEFT,
    CELL_FROM_RIGHT
  } cell_op_e;

endpackage

### rtl/core/ddas_cell.sv
// one cell of the digit chain: holds one position of both operands
module ddas_cell import ddas_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cell_op_e op_i,
  input  pair_t    left_i,
  input  pair_t    right_i,
  output pair_t    pair_o
);

  pair_t pair_q, pair_d;

  always_comb begin
    pair_d = pair_q;
    case (op_i)
      CELL_HOLD:       pair_d = pair_q;
      CELL_SHIFT_A:    pair_d.a = right_i.a;
      CELL_SHIFT_B:    pair_d.b = right_i.b;
      CELL_FROM_LEFT:  pair_d = left_i;
      CELL_FROM_RIGHT: pair_d = right_i;
      default:         pair_d = pair_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pair_q <= '0;
    end else begin
      pair_q <= pair_d;
    end
  end

  assign pair_o = pair_q;

endmodule

### rtl/core/ddas_digit_alu.sv
// serial bcd digit adder and subtractor with carry and borrow registers
module ddas_digit_alu import ddas_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              clear_i,
  input  logic              step_i,
  input  logic [DigitW-1:0] a_i,
  input  logic [DigitW-1:0] b_i,
  output logic [DigitW-1:0] sum_o,
  output logic [DigitW-1:0] diff_o,
  output logic              borrow_o
);

  logic          carry_q, borrow_q;
  logic [DigitW:0] sum_raw, sub_raw, a_ext;
  logic          carry_d, borrow_d;

  always_comb begin
    a_ext    = {1'b0, a_i};
    sum_raw  = a_ext + {1'b0, b_i} + {{DigitW{1'b0}}, carry_q};
    carry_d  = (sum_raw >= Radix);
    sum_o    = carry_d ? DigitW'(sum_raw - Radix) : sum_raw[DigitW-1:0];
    sub_raw  = {1'b0, b_i} + {{DigitW{1'b0}}, borrow_q};
    borrow_d = (a_ext < sub_raw);
    diff_o   = borrow_d ? DigitW'(a_ext + Radix - sub_raw) : DigitW'(a_ext - sub_raw);
  end

  assign borrow_o = borrow_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      carry_q  <= 1'b0;
      borrow_q <= 1'b0;
    end else if (clear_i) begin
      carry_q  <= 1'b0;
      borrow_q <= 1'b0;
    end else if (step_i) begin
      carry_q  <= carry_d;
      borrow_q <= borrow_d;
    end
  end

endmodule

### rtl/core/decimal_digit_add_sub.sv
// top level of the decimal digit adder and subtractor
//
// input channel: a transaction is taken at a rising edge with start_i high and
// busy_o low. mode_i picks the operand (0 first, 1 second), digit_i is the
// digit (values above nine count as nine), last_i marks the final digit.
// digits arrive most significant first and shift into a chain of DIGITS cells
// from the least significant end, so both numbers end up right-aligned;
// digits beyond the capacity of an operand are dropped.
// loading never raises busy_o, so digits can be taken back to back.
// the second operand's closing digit starts a run: first the chain rotates
// through one serial bcd adder/subtractor, least significant first, then the
// chain shifts out toward position 0, one result per cycle with
// result_valid_o high. the first result shows once the arithmetic pass is
// over; busy_o stays high until the chain has emptied.
// the final borrow of the subtraction doubles as the magnitude compare.
// emptying the chain leaves both stores cleared, counts clear at the end of
// the arithmetic pass. results cannot be stalled: each is on the ports for
// one cycle only. reset clears the chain, counts and control.
module decimal_digit_add_sub import ddas_pkg::*; #(
  parameter int unsigned DIGITS = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  logic              mode_i,
  input  logic [DigitW-1:0] digit_i,
  input  logic              last_i,
  output logic              result_valid_o,
  output logic [PosW-1:0]   position_o,
  output logic [DigitW-1:0] sum_digit_o,
  output logic [DigitW-1:0] diff_digit_o,
  output logic              diff_ok_o,
  output logic              end_of_run_o
);

  localparam int unsigned CntW = $clog2(DIGITS + 1);
  localparam int unsigned ExtW = (CntW > PosW) ? CntW : PosW;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_CALC,
    ST_EMIT
  } state_e;

  state_e          state_q, state_d;
  logic [CntW-1:0] step_q, step_d;
  logic [CntW-1:0] first_cnt_q, first_cnt_d;
  logic [CntW-1:0] second_cnt_q, second_cnt_d;
  logic            ok_q, ok_d;

  logic              accept;
  logic              last_step;
  logic [DigitW-1:0] digit_sat;
  cell_op_e          cell_op;
  pair_t             res_pair;
  pair_t             tail_in;
  pair_t             cell_q    [DIGITS];
  pair_t             left_in   [DIGITS];
  pair_t             right_in  [DIGITS];
  logic [DigitW-1:0] alu_sum, alu_diff;
  logic              alu_borrow;
  logic [ExtW-1:0]   pos_ext;

  assign accept    = start_i && (state_q == ST_LOAD);
  assign last_step = (step_q == CntW'(DIGITS - 1));
  assign digit_sat = (digit_i > MaxDigit) ? MaxDigit : digit_i;

  // chain control for this cycle
  always_comb begin
    cell_op = CELL_HOLD;
    case (state_q)
      ST_LOAD: begin
        if (accept && !mode_i && (first_cnt_q < CntW'(DIGITS))) begin
          cell_op = CELL_SHIFT_A;
        end else if (accept && mode_i && (second_cnt_q < CntW'(DIGITS))) begin
          cell_op = CELL_SHIFT_B;
        end
      end
      ST_CALC: cell_op = CELL_FROM_LEFT;
      ST_EMIT: cell_op = CELL_FROM_RIGHT;
      default: cell_op = CELL_HOLD;
    endcase
  end

  // new digit enters at the tail while loading, zeros while emptying
  always_comb begin
    tail_in = '0;
    if (state_q == ST_LOAD) begin
      tail_in.a = digit_sat;
      tail_in.b = digit_sat;
    end
  end

  // results of the serial unit re-enter at the head of the chain
  assign res_pair.a = alu_sum;
  assign res_pair.b = alu_diff;

  for (genvar i = 0; i < DIGITS; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign left_in[i] = res_pair;
    end else begin : g_mid_l
      assign left_in[i] = cell_q[i-1];
    end
    if (i == DIGITS - 1) begin : g_tail
      assign right_in[i] = tail_in;
    end else begin : g_mid_r
      assign right_in[i] = cell_q[i+1];
    end

    ddas_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .op_i    (cell_op),
      .left_i  (left_in[i]),
      .right_i (right_in[i]),
      .pair_o  (cell_q[i])
    );
  end

  // least significant pair sits at the tail during the arithmetic pass
  ddas_digit_alu u_alu (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .clear_i  (state_q == ST_LOAD),
    .step_i   (state_q == ST_CALC),
    .a_i      (cell_q[DIGITS-1].a),
    .b_i      (cell_q[DIGITS-1].b),
    .sum_o    (alu_sum),
    .diff_o   (alu_diff),
    .borrow_o (alu_borrow)
  );

  always_comb begin
    state_d      = state_q;
    step_d       = step_q;
    first_cnt_d  = first_cnt_q;
    second_cnt_d = second_cnt_q;
    ok_d         = ok_q;
    case (state_q)
      ST_LOAD: begin
        if (cell_op == CELL_SHIFT_A) begin
          first_cnt_d = first_cnt_q + 1'b1;
        end
        if (cell_op == CELL_SHIFT_B) begin
          second_cnt_d = second_cnt_q + 1'b1;
        end
        if (accept && mode_i && last_i) begin
          state_d = ST_CALC;
          step_d  = '0;
        end
      end
      ST_CALC: begin
        step_d = step_q + 1'b1;
        if (last_step) begin
          // no final borrow means second value is not above the first
          ok_d         = (second_cnt_q <= first_cnt_q) && !alu_borrow;
          first_cnt_d  = '0;
          second_cnt_d = '0;
          state_d      = ST_EMIT;
          step_d       = '0;
        end
      end
      ST_EMIT: begin
        step_d = step_q + 1'b1;
        if (last_step) begin
          state_d = ST_LOAD;
          step_d  = '0;
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_LOAD;
      step_q       <= '0;
      first_cnt_q  <= '0;
      second_cnt_q <= '0;
      ok_q         <= 1'b0;
    end else begin
      state_q      <= state_d;
      step_q       <= step_d;
      first_cnt_q  <= first_cnt_d;
      second_cnt_q <= second_cnt_d;
      ok_q         <= ok_d;
    end
  end

  // result ports read the head cell while the chain empties
  assign pos_ext        = ExtW'(step_q);
  assign busy_o         = (state_q != ST_LOAD);
  assign result_valid_o = (state_q == ST_EMIT);
  assign position_o     = pos_ext[PosW-1:0];
  assign sum_digit_o    = cell_q[0].a;
  assign diff_digit_o   = ok_q ? cell_q[0].b : '0;
  assign diff_ok_o      = ok_q;
  assign end_of_run_o   = (state_q == ST_EMIT) && last_step;

endmodule
